>>> src/lds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types, constants and register codes of the line delimiter splitter.
// ----------------------------------------------------------------------------
package lds_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 3;
   localparam int LIMIT_W     = 13;
   localparam int MATCH_W     = 2;
   localparam int USER_W      = 3;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 5;
   localparam int DELIM_SLOTS = 4;

   localparam int DELIM_MAX   = 4;
   localparam int DELIM_CAP   = (DELIM_MAX < DELIM_SLOTS) ? DELIM_MAX : DELIM_SLOTS;
   localparam int LINE_MAX    = 4096;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int PHASE_W     = 3;

   // Reset values of the configuration registers.
   localparam logic [LEN_W-1:0]   RST_DELIM_LEN  = LEN_W'(1);
   localparam logic [BYTE_W-1:0]  RST_DELIM_B0   = BYTE_W'(10);
   localparam logic [LIMIT_W-1:0] RST_LINE_LIMIT = LIMIT_W'(4096);

   // Bit positions inside rsp_tuser.
   localparam int USER_BYTE_VALID = 0;
   localparam int USER_LINE_END   = 1;
   localparam int USER_OVERFLOW   = 2;

   typedef enum logic [2:0] {
      REG_DELIM_LEN  = 3'd0,
      REG_DELIM_B0   = 3'd1,
      REG_DELIM_B1   = 3'd2,
      REG_DELIM_B2   = 3'd3,
      REG_DELIM_B3   = 3'd4,
      REG_LINE_LIMIT = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_BYTE,
      TAIL_END
   } tail_type;

   // One classified input byte: what the back end has to emit for it.
   typedef struct packed {
      logic                ovf;
      logic [MATCH_W-1:0]  rel_cnt;
      tail_type            tail;
      logic [BYTE_W-1:0]   data;
   } cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0]                        delim_len;
      logic [DELIM_SLOTS-1:0][BYTE_W-1:0]      delim;
      logic [LIMIT_W-1:0]                      line_limit;
   } cfg_type;

endpackage
`default_nettype wire

>>> src/lds_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lds_csr
// APB-style register file holding the delimiter and line limit settings.
// ----------------------------------------------------------------------------
module lds_csr
   import lds_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_idx_type'(csr_paddr[ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DELIM_LEN:  cfg_in.delim_len  = csr_pwdata[LEN_W-1:0];
            REG_DELIM_B0:   cfg_in.delim[0]   = csr_pwdata[BYTE_W-1:0];
            REG_DELIM_B1:   cfg_in.delim[1]   = csr_pwdata[BYTE_W-1:0];
            REG_DELIM_B2:   cfg_in.delim[2]   = csr_pwdata[BYTE_W-1:0];
            REG_DELIM_B3:   cfg_in.delim[3]   = csr_pwdata[BYTE_W-1:0];
            REG_LINE_LIMIT: cfg_in.line_limit = csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DELIM_LEN:  csr_prdata = DATA_W'(cfg_ff.delim_len);
         REG_DELIM_B0:   csr_prdata = DATA_W'(cfg_ff.delim[0]);
         REG_DELIM_B1:   csr_prdata = DATA_W'(cfg_ff.delim[1]);
         REG_DELIM_B2:   csr_prdata = DATA_W'(cfg_ff.delim[2]);
         REG_DELIM_B3:   csr_prdata = DATA_W'(cfg_ff.delim[3]);
         REG_LINE_LIMIT: csr_prdata = DATA_W'(cfg_ff.line_limit);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_len  <= RST_DELIM_LEN;
         cfg_ff.delim[0]   <= RST_DELIM_B0;
         cfg_ff.delim[1]   <= '0;
         cfg_ff.delim[2]   <= '0;
         cfg_ff.delim[3]   <= '0;
         cfg_ff.line_limit <= RST_LINE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> src/lds_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lds_front
// Classifies each input byte against the delimiter and tracks line length.
// ----------------------------------------------------------------------------
module lds_front
   import lds_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              in_valid,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic              q_ready,
   output logic                   in_ready,
   output logic                   q_push,
   output cmd_type                q_cmd
);

   logic [MATCH_W-1:0] match_ff, match_in;
   logic [LIMIT_W-1:0] length_ff, length_in;

   logic [LEN_W-1:0]   len_eff;
   logic [LIMIT_W-1:0] lim_eff;
   logic [MATCH_W-1:0] mc0;
   logic [LIMIT_W-1:0] ll0;
   logic [LIMIT_W-1:0] ll1;
   logic [LEN_W-1:0]   mc_next;
   logic               accept;
   cmd_type            cmd;

   assign in_ready = q_ready;
   assign accept   = in_valid & in_ready;

   always_comb begin
      len_eff = cfg.delim_len;
      if (len_eff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_eff > LEN_W'(DELIM_CAP)) begin
         len_eff = LEN_W'(DELIM_CAP);
      end
      lim_eff = cfg.line_limit;
      if (lim_eff == '0) begin
         lim_eff = LIMIT_W'(1);
      end else if (lim_eff > LIMIT_W'(LINE_MAX)) begin
         lim_eff = LIMIT_W'(LINE_MAX);
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.tail  = TAIL_NONE;
      cmd.data  = in_byte;
      mc0       = match_ff;
      ll0       = length_ff;
      // A shorter delimiter written since the last byte drops the held count.
      if ({1'b0, match_ff} >= len_eff) begin
         mc0 = '0;
      end
      if (length_ff >= lim_eff) begin
         cmd.ovf = 1'b1;
         mc0     = '0;
         ll0     = '0;
      end
      ll1       = ll0 + LIMIT_W'(1);
      mc_next   = {1'b0, mc0} + LEN_W'(1);
      match_in  = '0;
      length_in = ll1;
      if (in_byte == cfg.delim[mc0]) begin
         if (mc_next >= len_eff) begin
            cmd.tail  = TAIL_END;
            length_in = '0;
         end else begin
            match_in = mc_next[MATCH_W-1:0];
         end
      end else begin
         cmd.rel_cnt = mc0;
         // The byte that broke the match may itself start a new delimiter.
         if ((mc0 != '0) && (in_byte == cfg.delim[0])) begin
            if (len_eff == LEN_W'(1)) begin
               cmd.tail  = TAIL_END;
               length_in = '0;
            end else begin
               match_in = MATCH_W'(1);
            end
         end else begin
            cmd.tail = TAIL_BYTE;
         end
      end
   end

   assign q_cmd  = cmd;
   assign q_push = accept & (cmd.ovf | (cmd.rel_cnt != '0) | (cmd.tail != TAIL_NONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff  <= '0;
         length_ff <= '0;
      end else if (accept) begin
         match_ff  <= match_in;
         length_ff <= length_in;
      end
   end

endmodule
`default_nettype wire

>>> src/lds_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lds_queue
// Short command queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module lds_queue
   import lds_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         not_full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign not_full   = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> src/lds_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lds_back
// Expands queued commands into beats, one beat per cycle unless rsp_tready stalls.
// ----------------------------------------------------------------------------
module lds_back
   import lds_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               head_valid,
   input  wire cmd_type            head_cmd,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [BYTE_W-1:0]       rsp_tdata,
   output logic [USER_W-1:0]       rsp_tuser,
   output logic                    rsp_tlast
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               valid_ff, valid_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [USER_W-1:0]  user_ff, user_in;
   logic               last_ff, last_in;

   logic [PHASE_W-1:0] total;
   logic [PHASE_W-1:0] rel_idx;
   logic               load;

   assign load = head_valid & (~valid_ff | rsp_tready);

   always_comb begin
      // Beat order: overflow, released delimiter bytes, then the tail beat.
      total   = PHASE_W'(head_cmd.ovf) + PHASE_W'(head_cmd.rel_cnt)
              + PHASE_W'(head_cmd.tail != TAIL_NONE);
      rel_idx = phase_ff - PHASE_W'(head_cmd.ovf);
      byte_in = '0;
      user_in = '0;
      if (head_cmd.ovf && (phase_ff == '0)) begin
         user_in[USER_OVERFLOW] = 1'b1;
      end else if (rel_idx < PHASE_W'(head_cmd.rel_cnt)) begin
         byte_in                  = cfg.delim[rel_idx[MATCH_W-1:0]];
         user_in[USER_BYTE_VALID] = 1'b1;
      end else if (head_cmd.tail == TAIL_BYTE) begin
         byte_in                  = head_cmd.data;
         user_in[USER_BYTE_VALID] = 1'b1;
      end else begin
         user_in[USER_LINE_END] = 1'b1;
      end
      last_in  = (phase_ff == total - PHASE_W'(1));
      pop      = load & last_in;
      phase_in = phase_ff;
      if (load) begin
         phase_in = last_in ? '0 : phase_ff + PHASE_W'(1);
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

>>> src/line_delimiter_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_delimiter_splitter
// Splits a byte stream into lines ended by a 1 to 4 byte delimiter.
// ----------------------------------------------------------------------------
// An accepted byte's command is queued, then its first result beat is loaded
// into the output register. Throughput: one byte per cycle while each byte
// yields at most one beat and rsp_tready is high; a four-entry command queue
// absorbs longer bursts. Synchronous reset restores the register defaults and
// clears the match and length counters.
// ----------------------------------------------------------------------------
module line_delimiter_splitter
   import lds_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // req_tdata: [7:0] data_byte
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [BYTE_W-1:0] req_tdata,
   // rsp_tdata: [7:0] out_byte
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [BYTE_W-1:0]      rsp_tdata,
   // rsp_tuser: [0] byte_valid, [1] line_end, [2] overflow
   output logic [USER_W-1:0]      rsp_tuser,
   output logic                   rsp_tlast,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type cfg;
   logic    q_push;
   logic    q_not_full;
   logic    q_pop;
   logic    q_head_valid;
   cmd_type q_push_cmd;
   cmd_type q_head_cmd;

   lds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lds_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_byte  (req_tdata),
      .q_ready  (q_not_full),
      .in_ready (req_tready),
      .q_push   (q_push),
      .q_cmd    (q_push_cmd)
   );

   lds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .not_full   (q_not_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd)
   );

   lds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
